[sv/wspdc_pkg.sv]
package wspdc_pkg;

   // fixed field widths
   localparam int TIME_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int TARGET_W   = 15;
   localparam int ERR_W      = 24;
   localparam int DRIVE_W    = 9;
   localparam int PD_SHIFT   = 20;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 1;

   // saturation limits
   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd255;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -9'sd255;
   localparam logic signed [ERR_W-1:0]   ERR_MAX   = 24'sh7fffff;
   localparam logic signed [ERR_W-1:0]   ERR_MIN   = 24'sh800000;

   // register reset values
   localparam logic [GAIN_W-1:0] KP_RESET   = 16'd12800;
   localparam logic [GAIN_W-1:0] KD_RESET   = 16'd1280;
   localparam logic [GAIN_W-1:0] DIST_RESET = 16'd11765;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MOTOR_ENABLE = 3'd0,
      CSR_TARGET_LEFT  = 3'd1,
      CSR_TARGET_RIGHT = 3'd2,
      CSR_KP_GAIN      = 3'd3,
      CSR_KD_GAIN      = 3'd4,
      CSR_DIST_TICK    = 3'd5
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ERR,
      ST_KP_MUL,
      ST_KD_MUL,
      ST_WHEEL_DONE,
      ST_OUTPUT
   } ctrl_state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SPEED_MUL,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_ERR,
      OP_KP_MUL,
      OP_KD_MUL,
      OP_WHEEL_DONE,
      OP_OUTPUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      wheel;   // 0 left, 1 right
   } dp_cmd_type;

   typedef struct packed {
      logic active;       // loop enabled with a nonzero target
   } dp_sts_type;

endpackage

[sv/wheel_speed_pd_controller_core.sv]
// Wheel speed PD controller. Each sample transfer (timestamp and two encoder
// counts) produces one result transfer with both motor drives and a flag that
// tells whether the speed loop ran. With the loop running, a sample passes
// through the restoring speed divider, which makes one quotient bit a cycle and
// is shared by both wheels along with one multiplier; with the loop disabled or
// both targets zero the sample goes straight to the result register. A new sample
// is taken the cycle after the result is loaded, while that result waits for
// the consumer. Registers must be written only while the block is idle; the
// block itself does not enforce this.
module wheel_speed_pd_controller_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // timestamp_ms, left_count, right_count from bit 0 up, zero padded
   input  logic [((wspdc_pkg::TIME_W+2*COUNT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // left_drive, right_drive from bit 0 up, zero padded
   output logic [wspdc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // loop_active
   output logic [wspdc_pkg::RSP_USER_W-1:0]       rsp_tuser,
   input  logic                                   csr_wen,
   input  logic [wspdc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [wspdc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wspdc_pkg::*;

   localparam int REQ_W = ((TIME_W + 2*COUNT_WIDTH + 7) / 8) * 8;

   dp_cmd_type cmd;
   dp_sts_type sts;

   wspdc_ctrl #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   wspdc_datapath #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .REQ_W      (REQ_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_tdata),
      .rsp_user  (rsp_tuser)
   );

endmodule

[sv/wspdc_datapath.sv]
module wspdc_datapath #(
   parameter int COUNT_WIDTH = 16,
   parameter int REQ_W       = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [REQ_W-1:0]                     req_tdata,
   input  logic                                 csr_wen,
   input  logic [wspdc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [wspdc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wspdc_pkg::dp_cmd_type                cmd,
   output wspdc_pkg::dp_sts_type                sts,
   output logic [wspdc_pkg::RSP_DATA_W-1:0]     rsp_data,
   output logic [wspdc_pkg::RSP_USER_W-1:0]     rsp_user
);
   import wspdc_pkg::*;

   localparam int CW   = COUNT_WIDTH;
   localparam int BW   = (CW > ERR_W + 1) ? CW : ERR_W + 1;
   localparam int PW   = GAIN_W + 1 + BW;
   localparam int DIVW = CW + 11;
   localparam int EW   = (DIVW + 2 > ERR_W + 1) ? DIVW + 2 : ERR_W + 1;
   localparam int AW   = 44;
   localparam int XW   = (PW > AW) ? PW : AW;
   localparam int QW   = AW - PD_SHIFT;

   // input fields
   logic [TIME_W-1:0] now_time;
   logic [CW-1:0]     now_left;
   logic [CW-1:0]     now_right;

   assign now_time  = req_tdata[TIME_W-1:0];
   assign now_left  = req_tdata[TIME_W+CW-1:TIME_W];
   assign now_right = req_tdata[TIME_W+2*CW-1:TIME_W+CW];

   // configuration registers
   logic                       enable_ff, enable_in;
   logic signed [TARGET_W-1:0] tgt_l_ff, tgt_l_in, tgt_r_ff, tgt_r_in;
   logic [GAIN_W-1:0]          kp_ff, kp_in, kd_ff, kd_in, dist_ff, dist_in;

   // sample state
   logic              seen_ff, seen_in;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [CW-1:0]     prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic [CW-1:0]     delta_l_ff, delta_l_in, delta_r_ff, delta_r_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;

   // loop state
   logic signed [ERR_W-1:0]   err_l_ff, err_l_in, err_r_ff, err_r_in;
   logic signed [DRIVE_W-1:0] drv_l_ff, drv_l_in, drv_r_ff, drv_r_in;

   // work registers
   logic signed [PW-1:0]      prod_ff, prod_in;
   logic [DIVW-1:0]           quo_ff, quo_in;
   logic [TIME_W-1:0]         rem_ff, rem_in;
   logic                      neg_ff, neg_in;
   logic signed [ERR_W-1:0]   err_cur_ff, err_cur_in;
   logic signed [AW-1:0]      acc_ff, acc_in;

   // result register
   logic [DRIVE_W-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic               out_act_ff, out_act_in;

   logic                       active;
   logic signed [GAIN_W:0]     mul_a;
   logic signed [BW-1:0]       mul_b;
   logic signed [PW-1:0]       mul_p;
   logic [TIME_W-1:0]          prev_time_eff;
   logic [CW-1:0]              prev_l_eff, prev_r_eff;
   logic [CW-1:0]              delta_sel;
   logic signed [TARGET_W-1:0] tgt_sel;
   logic signed [ERR_W-1:0]    err_last_sel;
   logic signed [DRIVE_W-1:0]  drv_last_sel;
   logic signed [ERR_W:0]      err_diff;
   logic [PW-1:0]              prod_mag;
   logic [TIME_W:0]            rem_sh;
   logic signed [EW-1:0]       speed;
   logic signed [EW-1:0]       err_raw;
   logic signed [XW-1:0]       prod_x;
   logic signed [AW-1:0]       prod_ext;
   logic signed [AW-1:0]       pd_sum;
   logic signed [QW-1:0]       pd_quo;
   logic signed [DRIVE_W-1:0]  drv_new;

   assign active  = enable_ff && ((tgt_l_ff != '0) || (tgt_r_ff != '0));
   assign sts.active = active;

   // operand selection by wheel
   always_comb begin
      delta_sel    = cmd.wheel ? delta_r_ff : delta_l_ff;
      tgt_sel      = cmd.wheel ? tgt_r_ff : tgt_l_ff;
      err_last_sel = cmd.wheel ? err_r_ff : err_l_ff;
      drv_last_sel = cmd.wheel ? drv_r_ff : drv_l_ff;
      err_diff     = (ERR_W+1)'(err_cur_ff) - (ERR_W+1)'(err_last_sel);
   end

   // shared multiplier
   always_comb begin
      case (cmd.op)
         OP_KP_MUL: begin
            mul_a = $signed({1'b0, kp_ff});
            mul_b = BW'(err_cur_ff);
         end
         OP_KD_MUL: begin
            mul_a = $signed({1'b0, kd_ff});
            mul_b = BW'(err_diff);
         end
         default: begin
            mul_a = $signed({1'b0, dist_ff});
            mul_b = BW'($signed(delta_sel));
         end
      endcase
      mul_p = PW'(mul_a * mul_b);
   end

   // divider step, speed, error and drive arithmetic
   always_comb begin
      prev_time_eff = seen_ff ? prev_time_ff : now_time;
      prev_l_eff    = seen_ff ? prev_l_ff : now_left;
      prev_r_eff    = seen_ff ? prev_r_ff : now_right;

      prod_mag = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      rem_sh   = {rem_ff, quo_ff[DIVW-1]};

      if (elapsed_ff == '0) begin
         speed = '0;
      end else if (neg_ff) begin
         speed = -$signed(EW'(quo_ff));
      end else begin
         speed = $signed(EW'(quo_ff));
      end
      err_raw = EW'(tgt_sel) - speed;

      prod_x   = XW'(prod_ff);
      prod_ext = prod_x[AW-1:0];
      pd_sum   = acc_ff + prod_ext;
      pd_quo   = pd_sum[AW-1:PD_SHIFT];
      if (pd_sum[AW-1] && (pd_sum[PD_SHIFT-1:0] != '0)) begin
         pd_quo = pd_quo + QW'(1);
      end
      if (pd_quo > QW'(DRIVE_MAX)) begin
         drv_new = DRIVE_MAX;
      end else if (pd_quo < QW'(DRIVE_MIN)) begin
         drv_new = DRIVE_MIN;
      end else begin
         drv_new = pd_quo[DRIVE_W-1:0];
      end
   end

   // next state of all registers
   always_comb begin
      enable_in    = enable_ff;
      tgt_l_in     = tgt_l_ff;
      tgt_r_in     = tgt_r_ff;
      kp_in        = kp_ff;
      kd_in        = kd_ff;
      dist_in      = dist_ff;
      seen_in      = seen_ff;
      prev_time_in = prev_time_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      delta_l_in   = delta_l_ff;
      delta_r_in   = delta_r_ff;
      elapsed_in   = elapsed_ff;
      err_l_in     = err_l_ff;
      err_r_in     = err_r_ff;
      drv_l_in     = drv_l_ff;
      drv_r_in     = drv_r_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      err_cur_in   = err_cur_ff;
      acc_in       = acc_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      out_act_in   = out_act_ff;

      // register writes
      if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_MOTOR_ENABLE: enable_in = csr_wdata[0];
            CSR_TARGET_LEFT:  tgt_l_in  = $signed(csr_wdata[TARGET_W-1:0]);
            CSR_TARGET_RIGHT: tgt_r_in  = $signed(csr_wdata[TARGET_W-1:0]);
            CSR_KP_GAIN:      kp_in     = csr_wdata;
            CSR_KD_GAIN:      kd_in     = csr_wdata;
            CSR_DIST_TICK:    dist_in   = csr_wdata;
            default: ;
         endcase
      end

      case (cmd.op)
         // sample capture: wrapped deltas against the previous sample
         OP_CAPTURE: begin
            seen_in      = 1'b1;
            elapsed_in   = now_time - prev_time_eff;
            delta_l_in   = now_left - prev_l_eff;
            delta_r_in   = now_right - prev_r_eff;
            prev_time_in = now_time;
            prev_l_in    = now_left;
            prev_r_in    = now_right;
         end
         OP_SPEED_MUL: begin
            prod_in = mul_p;
         end
         // magnitude over 16 feeds the divider
         OP_DIV_LOAD: begin
            quo_in = prod_mag[DIVW+3:4];
            rem_in = '0;
            neg_in = prod_ff[PW-1];
         end
         // one restoring quotient bit
         OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, elapsed_ff}) begin
               rem_in = TIME_W'(rem_sh - {1'b0, elapsed_ff});
               quo_in = {quo_ff[DIVW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[TIME_W-1:0];
               quo_in = {quo_ff[DIVW-2:0], 1'b0};
            end
         end
         OP_ERR: begin
            if (err_raw > EW'(ERR_MAX)) begin
               err_cur_in = ERR_MAX;
            end else if (err_raw < EW'(ERR_MIN)) begin
               err_cur_in = ERR_MIN;
            end else begin
               err_cur_in = err_raw[ERR_W-1:0];
            end
         end
         OP_KP_MUL: begin
            prod_in = mul_p;
         end
         // last drive in Q20 plus the proportional term
         OP_KD_MUL: begin
            prod_in = mul_p;
            acc_in  = (AW'(drv_last_sel) <<< PD_SHIFT) + prod_ext;
         end
         OP_WHEEL_DONE: begin
            if (cmd.wheel) begin
               drv_r_in = drv_new;
               err_r_in = err_cur_ff;
            end else begin
               drv_l_in = drv_new;
               err_l_in = err_cur_ff;
            end
         end
         // result register; an idle loop zeroes the drives
         OP_OUTPUT: begin
            out_act_in = active;
            if (active) begin
               out_l_in = drv_l_ff;
               out_r_in = drv_r_ff;
            end else begin
               out_l_in = '0;
               out_r_in = '0;
               drv_l_in = '0;
               drv_r_in = '0;
            end
         end
         default: ;
      endcase
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         tgt_l_ff  <= '0;
         tgt_r_ff  <= '0;
         kp_ff     <= KP_RESET;
         kd_ff     <= KD_RESET;
         dist_ff   <= DIST_RESET;
         seen_ff   <= 1'b0;
         err_l_ff  <= '0;
         err_r_ff  <= '0;
         drv_l_ff  <= '0;
         drv_r_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         tgt_l_ff  <= tgt_l_in;
         tgt_r_ff  <= tgt_r_in;
         kp_ff     <= kp_in;
         kd_ff     <= kd_in;
         dist_ff   <= dist_in;
         seen_ff   <= seen_in;
         err_l_ff  <= err_l_in;
         err_r_ff  <= err_r_in;
         drv_l_ff  <= drv_l_in;
         drv_r_ff  <= drv_r_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_time_ff <= prev_time_in;
      prev_l_ff    <= prev_l_in;
      prev_r_ff    <= prev_r_in;
      delta_l_ff   <= delta_l_in;
      delta_r_ff   <= delta_r_in;
      elapsed_ff   <= elapsed_in;
      prod_ff      <= prod_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      err_cur_ff   <= err_cur_in;
      acc_ff       <= acc_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
      out_act_ff   <= out_act_in;
   end

   assign rsp_data = RSP_DATA_W'({out_r_ff, out_l_ff});
   assign rsp_user = out_act_ff;

`ifndef SYNTHESIS
   // stored drives never leave the saturated range
   a_drv_l_range: assert property (@(posedge clock) disable iff (reset)
      drv_l_ff != 9'sh100)
      else $error("left drive outside saturation range");
   a_drv_r_range: assert property (@(posedge clock) disable iff (reset)
      drv_r_ff != 9'sh100)
      else $error("right drive outside saturation range");
   // a zeroed result leaves the last drives cleared
   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUTPUT) && !active |=> (drv_l_ff == '0) && (drv_r_ff == '0))
      else $error("last drives not cleared when loop idle");
`endif

endmodule

[sv/wspdc_ctrl.sv]
module wspdc_ctrl #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output wspdc_pkg::dp_cmd_type cmd,
   input  wspdc_pkg::dp_sts_type sts
);
   import wspdc_pkg::*;

   localparam int DIVW  = COUNT_WIDTH + 11;
   localparam int CNT_W = $clog2(DIVW);

   ctrl_state_type   state_ff, state_in;
   logic             wheel_ff, wheel_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.active ? ST_SPEED_MUL : ST_OUTPUT;
            end
         end
         ST_SPEED_MUL: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIVW - 1)) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR:        state_in = ST_KP_MUL;
         ST_KP_MUL:     state_in = ST_KD_MUL;
         ST_KD_MUL:     state_in = ST_WHEEL_DONE;
         ST_WHEEL_DONE: state_in = wheel_ff ? ST_OUTPUT : ST_SPEED_MUL;
         ST_OUTPUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      req_tready   = 1'b0;
      cmd.op       = OP_NONE;
      cmd.wheel    = wheel_ff;
      wheel_in     = wheel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            wheel_in   = 1'b0;
            if (req_tvalid) begin
               cmd.op = OP_CAPTURE;
            end
         end
         ST_SPEED_MUL: cmd.op = OP_SPEED_MUL;
         ST_DIV_LOAD: begin
            cmd.op = OP_DIV_LOAD;
            cnt_in = '0;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_ERR:    cmd.op = OP_ERR;
         ST_KP_MUL: cmd.op = OP_KP_MUL;
         ST_KD_MUL: cmd.op = OP_KD_MUL;
         ST_WHEEL_DONE: begin
            cmd.op   = OP_WHEEL_DONE;
            wheel_in = 1'b1;
         end
         ST_OUTPUT: begin
            if (out_free) begin
               cmd.op       = OP_OUTPUT;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheel_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // a sample transfer always starts the sequence
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after sample transfer");
   // divider always starts from a cleared count
   a_div_count_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_LOAD |=> cnt_ff == '0)
      else $error("divider count not cleared");
   // loading the result register presents a result
   a_output_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_OUTPUT |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not presented after load");
   // second wheel always follows the first
   a_wheel_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WHEEL_DONE && !wheel_ff |=> state_ff == ST_SPEED_MUL && wheel_ff)
      else $error("right wheel step skipped");
`endif

endmodule
